[hdl/prst_pkg.sv]
// Shared types, constants and helpers for the protected resource slot table.
// Used by every module in this folder; it depends on nothing else.
package prst_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_OUT_W = 4;
    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_ENABLE_LINK  = 3'd0;
    localparam logic [OP_W-1:0] OP_DISABLE_LINK = 3'd1;
    localparam logic [OP_W-1:0] OP_ENABLE_NODE  = 3'd2;
    localparam logic [OP_W-1:0] OP_DISABLE_NODE = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_LINK    = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND_NODE    = 3'd5;

    // Key values held by one slot.
    typedef struct packed {
        logic [31:0] interface_index;
        logic [31:0] router_id;
        logic [7:0]  pseudonode_number;
    } t_entry;

    // One slot as seen by the compare unit.
    typedef struct packed {
        logic       link_flag;
        logic       node_flag;
        t_entry     keys;
        logic [SLOT_W-1:0] idx;
        logic       valid;
    } t_slot_rd;

    // Update of one slot.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic              link_flag;
        logic              node_flag;
        t_entry            keys;
    } t_slot_wr;

    // Verdict of the compare unit for the slot under test.
    typedef struct packed {
        logic   hit;
        logic   modify;
        logic   set_link;
        logic   set_node;
        t_entry keys;
    } t_match;

    // The result carries only the low bits of the slot number.
    function automatic logic [IDX_OUT_W-1:0] out_index(input logic [SLOT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[IDX_OUT_W-1:0];
    endfunction

endpackage

[hdl/prst_slot_store.sv]
// Slot storage: per-slot flags in flip-flops, cleared at reset, and a key memory.
// One read port with registered data, one write port. Depends on prst_pkg.
module prst_slot_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [prst_pkg::SLOT_W-1:0]      i_rd_addr,
    input  prst_pkg::t_slot_wr               i_wr,
    output prst_pkg::t_slot_rd               o_rd
);

    logic [prst_pkg::SLOTS-1:0] r_link_flag;
    logic [prst_pkg::SLOTS-1:0] r_node_flag;
    prst_pkg::t_entry           r_keys [prst_pkg::SLOTS];
    prst_pkg::t_slot_rd         r_rd;

    // Flags clear at reset; a cleared slot never compares its keys, so the
    // key memory needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_flag <= '0;
            r_node_flag <= '0;
        end else if (i_wr.we) begin
            r_link_flag[i_wr.addr] <= i_wr.link_flag;
            r_node_flag[i_wr.addr] <= i_wr.node_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_keys[i_wr.addr] <= i_wr.keys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd.valid <= 1'b0;
        end else begin
            r_rd.valid <= i_rd_en;
        end
        r_rd.link_flag <= r_link_flag[i_rd_addr];
        r_rd.node_flag <= r_node_flag[i_rd_addr];
        r_rd.keys      <= r_keys[i_rd_addr];
        r_rd.idx       <= i_rd_addr;
    end

    assign o_rd = r_rd;

endmodule

[hdl/prst_match.sv]
// Shared compare unit: judges one slot against the operation and its keys.
// Decides hit, whether the slot changes, and the new slot contents. Depends on prst_pkg.
module prst_match (
    input  logic [prst_pkg::OP_W-1:0] i_op,
    input  prst_pkg::t_entry          i_keys,
    input  prst_pkg::t_slot_rd        i_slot,
    output prst_pkg::t_match          o_match
);

    logic free_slot;
    logic link_eq;
    logic node_eq;

    assign free_slot = !i_slot.link_flag && !i_slot.node_flag;
    assign link_eq   = i_slot.link_flag &&
                       (i_slot.keys.interface_index == i_keys.interface_index);
    assign node_eq   = i_slot.node_flag &&
                       (i_slot.keys.router_id == i_keys.router_id) &&
                       (i_slot.keys.pseudonode_number == i_keys.pseudonode_number);

    always_comb begin
        o_match = '0;
        unique case (i_op)
            prst_pkg::OP_ENABLE_LINK: begin
                o_match.hit    = free_slot;
                o_match.modify = 1'b1;
                o_match.set_link = 1'b1;
                o_match.keys.interface_index = i_keys.interface_index;
            end
            prst_pkg::OP_DISABLE_LINK: begin
                o_match.hit    = link_eq;
                o_match.modify = 1'b1;
            end
            prst_pkg::OP_ENABLE_NODE: begin
                o_match.hit    = free_slot;
                o_match.modify = 1'b1;
                o_match.set_node = 1'b1;
                o_match.keys.router_id = i_keys.router_id;
                o_match.keys.pseudonode_number = i_keys.pseudonode_number;
            end
            prst_pkg::OP_DISABLE_NODE: begin
                o_match.hit    = node_eq;
                o_match.modify = 1'b1;
            end
            prst_pkg::OP_FIND_LINK: begin
                o_match.hit = link_eq;
            end
            prst_pkg::OP_FIND_NODE: begin
                o_match.hit = node_eq;
            end
            default: begin
                o_match = '0;
            end
        endcase
    end

endmodule

[hdl/protected_resource_slot_table.sv]
// Top level of the protected resource slot table: command port and scan sequencer.
// Instantiates prst_slot_store and prst_match; depends on prst_pkg.
//
// Usage: raise start with op and the key fields; the item is taken at the
// rising edge where start is high and busy is low. Busy then stays high
// while the sequencer walks the slots from slot 0 upward, one slot per
// cycle, through the single compare unit. The key memory has a registered
// read port, so each slot is judged in the cycle after its address is issued.
// Enable claims the lowest free slot, disable clears the lowest matching
// slot, find reports the lowest matching slot; an undefined op matches
// nothing. The scan stops at the first hit.
// A miss ends the scan once the last slot has been judged. Busy falls in the
// cycle the result is shown, so the next item can be accepted at the end
// of that cycle.
// The result (o_found, o_slot_index) is shown for exactly one cycle with
// o_valid high; the receiver cannot stall it. o_slot_index is the low four
// bits of the slot number and is zero when o_found is low.
// Reset is synchronous and active low: all flags clear at once, so the
// table is empty and the block is idle in the first cycle after reset.
module protected_resource_slot_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [prst_pkg::OP_W-1:0]           i_op,
    input  logic [31:0]                         i_interface_index,
    input  logic [31:0]                         i_router_id,
    input  logic [7:0]                          i_pseudonode_number,
    output logic                                o_valid,
    output logic                                o_found,
    output logic [prst_pkg::IDX_OUT_W-1:0]      o_slot_index
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    localparam logic [prst_pkg::SLOT_W-1:0] LAST_SLOT = prst_pkg::SLOT_W'(prst_pkg::SLOTS - 1);

    t_state                          r_state;
    logic [prst_pkg::OP_W-1:0]       r_op;
    prst_pkg::t_entry                r_keys;
    logic [prst_pkg::SLOT_W-1:0]     r_idx;
    logic                            r_issue;
    logic                            r_valid;
    logic                            r_found;
    logic [prst_pkg::IDX_OUT_W-1:0]  r_slot_index;

    prst_pkg::t_slot_rd              slot_rd;
    prst_pkg::t_match                match;
    prst_pkg::t_slot_wr              slot_wr;
    logic                            accept;
    logic                            judge;
    logic                            finish;

    assign accept = start && (r_state == ST_IDLE);
    // A slot read is judged only while this item's scan is running.
    assign judge  = (r_state == ST_SCAN) && slot_rd.valid;
    assign finish = judge && (match.hit || (slot_rd.idx == LAST_SLOT));

    prst_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_issue && (r_state == ST_SCAN) && !finish),
        .i_rd_addr (r_idx),
        .i_wr      (slot_wr),
        .o_rd      (slot_rd)
    );

    prst_match u_match (
        .i_op    (r_op),
        .i_keys  (r_keys),
        .i_slot  (slot_rd),
        .o_match (match)
    );

    // A hit on a modifying operation rewrites that slot; a disable writes
    // cleared flags and zero keys.
    always_comb begin
        slot_wr.we        = judge && match.hit && match.modify;
        slot_wr.addr      = slot_rd.idx;
        slot_wr.link_flag = match.set_link;
        slot_wr.node_flag = match.set_node;
        slot_wr.keys      = match.keys;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_issue <= 1'b0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_slot_index <= '0;
            r_idx   <= '0;
        end else begin
            // The result strobe lasts exactly the cycle after the scan ends.
            r_valid <= finish;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                        r_issue <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (finish) begin
                        r_state      <= ST_IDLE;
                        r_issue      <= 1'b0;
                        r_found      <= match.hit;
                        r_slot_index <= match.hit ? prst_pkg::out_index(slot_rd.idx) : '0;
                    end else if (r_issue) begin
                        // Address issue runs ahead of the compare by one slot.
                        if (r_idx == LAST_SLOT) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op                  <= i_op;
            r_keys.interface_index   <= i_interface_index;
            r_keys.router_id         <= i_router_id;
            r_keys.pseudonode_number <= i_pseudonode_number;
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_slot_index = r_slot_index;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not start a scan");
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy)
        else $error("result shown while scan still running");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_found) |-> (r_slot_index == '0))
        else $error("miss carries a nonzero slot index");
    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_wr.we |-> (finish && (r_state == ST_SCAN)))
        else $error("slot written outside the finishing scan step");
    a_write_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_wr.we |=> (r_valid && r_found))
        else $error("slot update without a found result");
`endif

endmodule
